// ===== src/som_1d_train_step_top_assert.svh =====
// Assertion macros for the SOM training block.
`ifndef SOM_1D_TRAIN_STEP_TOP_ASSERT_SVH
`define SOM_1D_TRAIN_STEP_TOP_ASSERT_SVH
`define SOM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/som_pkg.sv =====
// Shared constants for the SOM training block.
package som_pkg;
  localparam int WW = 16;
  localparam int DW = 34;
  localparam logic [1:0] OP_TRAIN = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [15:0] RATE_RESET = 16'd6554;
endpackage

// ===== src/som_if.sv =====
// Valid/ready channel interfaces for the SOM training block.
interface som_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] feature_0;
  logic [15:0] feature_1;
  logic [15:0] feature_2;
  logic [15:0] feature_3;
  logic [3:0]  neuron_index;
  logic [1:0]  feature_index;
  logic [15:0] weight_value;
  modport source (output valid, operation, feature_0, feature_1, feature_2, feature_3,
                  neuron_index, feature_index, weight_value, input ready);
  modport sink (input valid, operation, feature_0, feature_1, feature_2, feature_3,
                neuron_index, feature_index, weight_value, output ready);
endinterface

interface som_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  winner_index;
  logic [33:0] winner_distance;
  logic [15:0] read_value;
  modport source (output valid, winner_index, winner_distance, read_value, input ready);
  modport sink (input valid, winner_index, winner_distance, read_value, output ready);
endinterface

interface som_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/som_1d_train_step_top.sv =====
// Top level of the 1-D self-organizing map training block.
// Usage:
//  - in: one transaction per item (train, write weight, read weight).
//  - out: one result transaction per item, held until taken.
//  - cfg: writes the update step rate (Q0.16); write only while idle.
// Each neuron has its own lane that holds its weights and computes its
// squared distance; a merge stage picks the nearest neuron (lowest index
// on ties); the winner and its neighbors then update together.
// A train passes through the square, sum, merge and update stages to the
// result; a write or read goes straight to the result. One item at a
// time: input is taken only while idle, so a new item waits until the
// result is taken and the block is back in idle.
// Reset clears control and sets the step rate to 6554; weights are
// undefined until written. A stalled receiver holds the result register
// and input is not taken until the result leaves.
`include "som_1d_train_step_top_assert.svh"
module som_1d_train_step_top import som_pkg::*; #(
  parameter int NEURONS  = 16,
  parameter int FEATURES = 2
) (
  input  logic clk,
  input  logic rst,
  som_in_if.sink    in_ch,
  som_out_if.source out_ch,
  som_cfg_if.sink   cfg
);
  localparam int IW = $clog2(NEURONS);
  localparam int FW = $clog2(FEATURES+1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MIN  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [15:0] step_rate;
  logic [FEATURES*WW-1:0] x;
  logic [DW-1:0] lane_d [NEURONS];
  logic [NEURONS*DW-1:0] lane_d_flat;
  logic [FEATURES*WW-1:0] w_all [NEURONS];
  logic [IW-1:0] best;
  logic [DW-1:0] best_d;
  logic in_ok;
  logic addr_ok;
  logic [WW-1:0] x_in [4];

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign in_ok = in_ch.valid && in_ch.ready;
  assign addr_ok = (32'(in_ch.neuron_index) < NEURONS) && (32'(in_ch.feature_index) < FEATURES);
  assign x_in[0] = in_ch.feature_0;
  assign x_in[1] = in_ch.feature_1;
  assign x_in[2] = in_ch.feature_2;
  assign x_in[3] = in_ch.feature_3;

  always_ff @(posedge clk) begin
    if (rst) step_rate <= RATE_RESET;
    else if (cfg.valid) step_rate <= cfg.data;
  end

  always_ff @(posedge clk) begin
    if (in_ok) begin
      for (int f = 0; f < FEATURES; f++) x[f*WW +: WW] <= x_in[f];
    end
  end

  genvar g;
  generate
    for (g = 0; g < NEURONS; g++) begin : g_lane
      logic upd;
      assign upd = (state == S_UPD) &&
                   ((32'(best) == g) || (32'(best) + 1 == g) || (32'(best) == g + 1));
      som_lane #(.FEATURES(FEATURES)) u_lane (
        .clk(clk), .x(x), .dist_en(state == S_SQ), .sq_sum(lane_d[g]),
        .rate(step_rate), .upd_en(upd),
        .wr_en(in_ok && in_ch.operation == OP_WRITE && addr_ok &&
               32'(in_ch.neuron_index) == g),
        .wr_f(FW'(in_ch.feature_index)), .wr_data(in_ch.weight_value),
        .w_all(w_all[g]));
      assign lane_d_flat[g*DW +: DW] = lane_d[g];
    end
  endgenerate

  som_argmin #(.NEURONS(NEURONS)) u_min (
    .clk(clk), .lane_d(lane_d_flat), .best(best), .best_d(best_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_ok) state <= (in_ch.operation == OP_TRAIN) ? S_SQ : S_OUT;
        S_SQ:   state <= S_SUM;
        S_SUM:  state <= S_MIN;
        S_MIN:  state <= S_UPD;
        S_UPD:  state <= S_OUT;
        S_OUT:  if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (in_ok) begin
      out_ch.winner_index    <= '0;
      out_ch.winner_distance <= '0;
      out_ch.read_value      <= '0;
      if (in_ch.operation == OP_READ && addr_ok) begin
        out_ch.read_value <= w_all[IW'(in_ch.neuron_index)]
                             [32'(in_ch.feature_index)*WW +: WW];
      end
    end else if (state == S_UPD) begin
      out_ch.winner_index    <= 4'(best);
      out_ch.winner_distance <= best_d;
    end
  end

  `SOM_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ch.ready, "accept while busy")
  `SOM_ASSERT_NEXT(a_train_seq, clk, rst, in_ok && in_ch.operation == OP_TRAIN, state == S_SQ, "train sequence")
  `SOM_ASSERT_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.winner_distance), "result dropped")
endmodule

// ===== src/som_lane.sv =====
// One neuron lane: holds the neuron's weights, computes distance, applies update.
module som_lane import som_pkg::*; #(
  parameter int FEATURES = 2
) (
  input  logic                      clk,
  input  logic [FEATURES*WW-1:0]    x,
  input  logic                      dist_en,
  output logic [DW-1:0]             sq_sum,
  input  logic [15:0]               rate,
  input  logic                      upd_en,
  input  logic                      wr_en,
  input  logic [$clog2(FEATURES+1)-1:0] wr_f,
  input  logic [WW-1:0]             wr_data,
  output logic [FEATURES*WW-1:0]    w_all
);
  logic [WW-1:0] w [FEATURES];
  logic [2*WW-1:0] sq [FEATURES];
  logic [DW-1:0] sum;

  always_comb begin
    sum = '0;
    for (int f = 0; f < FEATURES; f++) begin
      sum = sum + DW'(sq[f]);
    end
  end

  // Stage 1: squares per feature; stage 2: sum.
  always_ff @(posedge clk) begin
    for (int f = 0; f < FEATURES; f++) begin
      logic signed [WW:0] e;
      logic [WW-1:0] ae;
      e = $signed({1'b0, x[f*WW +: WW]}) - $signed({1'b0, w[f]});
      // |e| fits in WW bits
      ae = e[WW] ? WW'(-e) : WW'(e);
      if (dist_en) sq[f] <= {{WW{1'b0}}, ae} * {{WW{1'b0}}, ae};
    end
    sq_sum <= sum;
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < FEATURES; f++) begin
      logic signed [WW:0]   d;
      logic signed [WW+17:0] p;
      d = $signed({1'b0, x[f*WW +: WW]}) - $signed({1'b0, w[f]});
      p = $signed({1'b0, rate}) * d;
      if (wr_en && (32'(wr_f) == f)) begin
        w[f] <= wr_data;
      end else if (upd_en) begin
        w[f] <= WW'($signed({1'b0, w[f]}) + (p >>> 16));
      end
    end
  end

  always_comb begin
    for (int f = 0; f < FEATURES; f++) w_all[f*WW +: WW] = w[f];
  end
endmodule

// ===== src/som_argmin.sv =====
// Merge stage: lowest-index minimum over all lane distances.
module som_argmin import som_pkg::*; #(
  parameter int NEURONS = 16
) (
  input  logic                       clk,
  input  logic [NEURONS*DW-1:0]      lane_d,
  output logic [$clog2(NEURONS)-1:0] best,
  output logic [DW-1:0]              best_d
);
  localparam int IW = $clog2(NEURONS);
  localparam int P  = 1 << IW;
  logic [P*DW-1:0] pad_d;
  logic [DW-1:0] td [2*P-1];
  logic [IW-1:0] ti [2*P-1];

  // Compare tree; unused leaves hold all ones and never win.
  always_comb begin
    pad_d = '1;
    pad_d[NEURONS*DW-1:0] = lane_d;
    for (int i = 0; i < P; i++) begin
      td[P-1+i] = pad_d[i*DW +: DW];
      ti[P-1+i] = IW'(i);
    end
    // Left child covers lower indexes, so it keeps ties.
    for (int n = P-2; n >= 0; n--) begin
      if (td[2*n+2] < td[2*n+1]) begin
        td[n] = td[2*n+2];
        ti[n] = ti[2*n+2];
      end else begin
        td[n] = td[2*n+1];
        ti[n] = ti[2*n+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    best   <= ti[0];
    best_d <= td[0];
  end
endmodule
